### hdl/mts_pkg.sv
`timescale 1ns / 1ps

package mts_pkg;

    // Stack geometry and value width.
    localparam int STACK_DEPTH = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Action codes carried in the command item.
    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;
    localparam logic [1:0] ACT_PEEK = 2'd2;

    // Status codes carried in the response item.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    typedef struct packed {
        logic [1:0]  action;
        logic signed [31:0] data_value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic signed [31:0] popped_value;
        logic signed [31:0] top_value;
        logic signed [31:0] max_value;
        logic        is_empty;
    } rsp_t;

    // One entry of the maximum stack: a maximum and how often it repeats.
    typedef struct packed {
        value_t           max_value;
        logic [CNT_W-1:0] count;
    } pair_t;

    // What a cell does with its entry at a clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT_UP
    } cell_op_t;

    typedef struct packed {
        cell_op_t elem_op;
        cell_op_t pair_op;
    } cell_ctrl_t;

    // Fill levels of both stacks, exported for checking.
    typedef struct packed {
        logic [DEPTH_W-1:0] elem_depth;
        logic [DEPTH_W-1:0] max_depth;
    } depth_t;

endpackage

### hdl/max_tracking_stack_unit.sv
`timescale 1ns / 1ps

// Stack of signed values that also reports its running maximum.
// Command channel (cmd_valid, cmd_ready, cmd): each item is a push, a pop or
// a peek (the unused action code also peeks). Response channel (rsp_valid,
// rsp_ready, rsp): exactly one item per command, carrying status, popped
// value, new top, new maximum and an empty flag.
// Both stacks are a row of STACK_DEPTH cells with the head cells as the tops;
// every push or pop that is not refused shifts all element cells by one place
// at once, and the maximum cells shift only when a pair opens or closes.
// The response is registered: it appears in the cycle after the command is accepted.
// Throughput: one command per cycle while responses are taken; the single
// response register is what limits it.
// When the receiver stalls, the response is held and cmd_ready drops until
// it is taken; no item is lost. cmd_ready stays high while the response
// register is empty or being drained in the same cycle.
// Reset empties both stacks at once and clears any pending response; the
// cell contents are not cleared, since only entries below the fill level
// are ever read.
// A push to a full stack returns the full status and changes nothing.

module max_tracking_stack_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  mts_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output mts_pkg::rsp_t rsp
);
    import mts_pkg::*;

    logic       fire;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    rsp_t       rsp_reg;
    rsp_t       result;
    cell_ctrl_t head_ctrl;
    cell_ctrl_t body_ctrl;
    value_t     load_elem;
    pair_t      load_pair;
    depth_t     depths;
    value_t     elem_q [STACK_DEPTH];
    pair_t      pair_q [STACK_DEPTH];

    assign cmd_ready = !rsp_valid_reg || rsp_ready;
    assign fire      = cmd_valid && cmd_ready;

    mts_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .cmd         (cmd),
        .head_elem   (elem_q[0]),
        .second_elem (elem_q[1]),
        .head_pair   (pair_q[0]),
        .second_pair (pair_q[1]),
        .head_ctrl   (head_ctrl),
        .body_ctrl   (body_ctrl),
        .load_elem   (load_elem),
        .load_pair   (load_pair),
        .result      (result),
        .depths      (depths)
    );

    // Row of cells; cell 0 is the top of both stacks.
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        value_t     elem_up;
        value_t     elem_down;
        pair_t      pair_up;
        pair_t      pair_down;
        cell_ctrl_t ctrl;

        if (i == 0)
        begin : g_head
            assign elem_up = load_elem;
            assign pair_up = load_pair;
            assign ctrl    = head_ctrl;
        end
        else
        begin : g_body
            assign elem_up = elem_q[i-1];
            assign pair_up = pair_q[i-1];
            assign ctrl    = body_ctrl;
        end

        if (i == STACK_DEPTH - 1)
        begin : g_tail
            assign elem_down = '0;
            assign pair_down = '0;
        end
        else
        begin : g_link
            assign elem_down = elem_q[i+1];
            assign pair_down = pair_q[i+1];
        end

        mts_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .elem_up   (elem_up),
            .elem_down (elem_down),
            .pair_up   (pair_up),
            .pair_down (pair_down),
            .elem      (elem_q[i]),
            .pair      (pair_q[i])
        );
    end

    // Response register: loaded on an accepted item, emptied when taken.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The maximum stack never outgrows the element stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        depths.max_depth <= depths.elem_depth)
    else $error("maximum stack deeper than element stack");

    // Elements present always means a maximum is tracked, and the reverse.
    assert property (@(posedge clk) disable iff (!rst_n)
        (depths.elem_depth == '0) == (depths.max_depth == '0))
    else $error("element and maximum stacks disagree on emptiness");

    // An empty response reports zero top and maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_empty |-> rsp.top_value == '0 && rsp.max_value == '0)
    else $error("empty response carries nonzero values");

    // A refused push can only happen on a non-empty stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STATUS_FULL |-> !rsp.is_empty)
    else $error("full status on an empty stack");

endmodule

### hdl/mts_cell.sv
`timescale 1ns / 1ps

module mts_cell (
    input  logic               clk,
    input  mts_pkg::cell_ctrl_t ctrl,
    input  mts_pkg::value_t    elem_up,
    input  mts_pkg::value_t    elem_down,
    input  mts_pkg::pair_t     pair_up,
    input  mts_pkg::pair_t     pair_down,
    output mts_pkg::value_t    elem,
    output mts_pkg::pair_t     pair
);
    import mts_pkg::*;

    value_t elem_reg;
    value_t elem_next;
    pair_t  pair_reg;
    pair_t  pair_next;

    // Element slot: take from the neighbor above on a push, from below on a pop.
    always_comb
    begin
        case (ctrl.elem_op)
            CELL_LOAD:     elem_next = elem_up;
            CELL_SHIFT_UP: elem_next = elem_down;
            default:       elem_next = elem_reg;
        endcase
    end

    // Maximum slot moves the same way, under its own control.
    always_comb
    begin
        case (ctrl.pair_op)
            CELL_LOAD:     pair_next = pair_up;
            CELL_SHIFT_UP: pair_next = pair_down;
            default:       pair_next = pair_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
        pair_reg <= pair_next;
    end

    assign elem = elem_reg;
    assign pair = pair_reg;

endmodule

### hdl/mts_ctrl.sv
`timescale 1ns / 1ps

module mts_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  mts_pkg::cmd_t       cmd,
    input  mts_pkg::value_t     head_elem,
    input  mts_pkg::value_t     second_elem,
    input  mts_pkg::pair_t      head_pair,
    input  mts_pkg::pair_t      second_pair,
    output mts_pkg::cell_ctrl_t head_ctrl,
    output mts_pkg::cell_ctrl_t body_ctrl,
    output mts_pkg::value_t     load_elem,
    output mts_pkg::pair_t      load_pair,
    output mts_pkg::rsp_t       result,
    output mts_pkg::depth_t     depths
);
    import mts_pkg::*;

    logic [DEPTH_W-1:0] elem_depth_reg;
    logic [DEPTH_W-1:0] elem_depth_next;
    logic [DEPTH_W-1:0] max_depth_reg;
    logic [DEPTH_W-1:0] max_depth_next;
    cell_op_t           head_elem_op;
    cell_op_t           head_pair_op;
    cell_op_t           body_elem_op;
    cell_op_t           body_pair_op;
    logic [1:0]         status;
    value_t             popped;
    value_t             new_top;
    value_t             new_max;
    value_t             push_value;

    assign push_value = value_t'(cmd.data_value);

    // Decode the item into cell moves and the new stack heads.
    always_comb
    begin
        head_elem_op    = CELL_HOLD;
        head_pair_op    = CELL_HOLD;
        body_elem_op    = CELL_HOLD;
        body_pair_op    = CELL_HOLD;
        load_elem       = push_value;
        load_pair       = '{max_value: push_value, count: CNT_W'(1)};
        elem_depth_next = elem_depth_reg;
        max_depth_next  = max_depth_reg;
        status          = STATUS_OK;
        popped          = '0;
        new_top         = head_elem;
        new_max         = head_pair.max_value;
        case (cmd.action)
            ACT_PUSH:
            begin
                if (elem_depth_reg == DEPTH_W'(STACK_DEPTH))
                begin
                    status = STATUS_FULL;
                end
                else
                begin
                    head_elem_op    = CELL_LOAD;
                    body_elem_op    = CELL_LOAD;
                    elem_depth_next = elem_depth_reg + DEPTH_W'(1);
                    new_top         = push_value;
                    if (max_depth_reg == '0 || push_value > head_pair.max_value)
                    begin
                        // A new, larger maximum opens a pair.
                        head_pair_op   = CELL_LOAD;
                        body_pair_op   = CELL_LOAD;
                        max_depth_next = max_depth_reg + DEPTH_W'(1);
                        new_max        = push_value;
                    end
                    else if (push_value == head_pair.max_value)
                    begin
                        // Repeat of the current maximum bumps its count in place.
                        head_pair_op = CELL_LOAD;
                        load_pair    = '{max_value: head_pair.max_value,
                                         count: head_pair.count + CNT_W'(1)};
                    end
                end
            end
            ACT_POP:
            begin
                if (elem_depth_reg == '0)
                begin
                    status = STATUS_EMPTY;
                end
                else
                begin
                    head_elem_op    = CELL_SHIFT_UP;
                    body_elem_op    = CELL_SHIFT_UP;
                    elem_depth_next = elem_depth_reg - DEPTH_W'(1);
                    popped          = head_elem;
                    new_top         = second_elem;
                    if (max_depth_reg != '0 && head_elem == head_pair.max_value)
                    begin
                        if (head_pair.count <= CNT_W'(1))
                        begin
                            // Last copy of this maximum leaves: drop the pair.
                            head_pair_op   = CELL_SHIFT_UP;
                            body_pair_op   = CELL_SHIFT_UP;
                            max_depth_next = max_depth_reg - DEPTH_W'(1);
                            new_max        = second_pair.max_value;
                        end
                        else
                        begin
                            head_pair_op = CELL_LOAD;
                            load_pair    = '{max_value: head_pair.max_value,
                                             count: head_pair.count - CNT_W'(1)};
                        end
                    end
                end
            end
            default:
            begin
                if (elem_depth_reg == '0)
                begin
                    status = STATUS_EMPTY;
                end
            end
        endcase
    end

    // Cells move only on an accepted item.
    always_comb
    begin
        head_ctrl = '{elem_op: CELL_HOLD, pair_op: CELL_HOLD};
        body_ctrl = '{elem_op: CELL_HOLD, pair_op: CELL_HOLD};
        if (fire)
        begin
            head_ctrl = '{elem_op: head_elem_op, pair_op: head_pair_op};
            body_ctrl = '{elem_op: body_elem_op, pair_op: body_pair_op};
        end
    end

    // Response as the stack stands after the item.
    always_comb
    begin
        result.status       = status;
        result.popped_value = 32'(popped);
        if (elem_depth_next == '0)
        begin
            result.top_value = '0;
            result.max_value = '0;
            result.is_empty  = 1'b1;
        end
        else
        begin
            result.top_value = 32'(new_top);
            result.max_value = (max_depth_next != '0) ? 32'(new_max) : 32'sd0;
            result.is_empty  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_depth_reg <= '0;
            max_depth_reg  <= '0;
        end
        else if (fire)
        begin
            elem_depth_reg <= elem_depth_next;
            max_depth_reg  <= max_depth_next;
        end
    end

    assign depths = '{elem_depth: elem_depth_reg, max_depth: max_depth_reg};

endmodule

### tb/max_tracking_stack_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the max-tracking stack, keeps its own copy of the
// element stack and the maximum stack, and compares every response item with
// the oldest predicted one.
module max_tracking_stack_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  logic          cmd_ready,
    input  mts_pkg::cmd_t cmd,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  mts_pkg::rsp_t rsp,
    output int            fail_count,
    output int            pending_results
);
    import mts_pkg::*;

    // Shadow copy of both stacks.
    value_t           stack_elems [STACK_DEPTH];
    value_t           peak_vals   [STACK_DEPTH];
    int unsigned      peak_reps   [STACK_DEPTH];
    int               elem_count;
    int               peak_count;

    // Responses predicted but not yet seen, oldest first.
    rsp_t             expected_rsps [$];
    rsp_t             want;

    initial
    begin
        fail_count      = 0;
        pending_results = 0;
        elem_count      = 0;
        peak_count      = 0;
    end

    // Apply one command to the shadow stacks and return the response it causes.
    function automatic rsp_t apply_stack_op(input cmd_t c);
        rsp_t   r;
        value_t v;
        int     t;
        r = '0;
        r.status = STATUS_OK;
        case (c.action)
            ACT_PUSH:
            begin
                if (elem_count >= STACK_DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    v = c.data_value;
                    stack_elems[elem_count] = v;
                    elem_count++;
                    if (peak_count == 0)
                    begin
                        peak_vals[0] = v;
                        peak_reps[0] = 1;
                        peak_count   = 1;
                    end
                    else
                    begin
                        t = peak_count - 1;
                        if (v == peak_vals[t])
                            peak_reps[t]++;
                        else if (v > peak_vals[t] && peak_count < STACK_DEPTH)
                        begin
                            peak_vals[peak_count] = v;
                            peak_reps[peak_count] = 1;
                            peak_count++;
                        end
                    end
                end
            end
            ACT_POP:
            begin
                if (elem_count == 0)
                    r.status = STATUS_EMPTY;
                else
                begin
                    elem_count--;
                    v = stack_elems[elem_count];
                    r.popped_value = v;
                    if (peak_count != 0)
                    begin
                        t = peak_count - 1;
                        if (v == peak_vals[t])
                        begin
                            if (peak_reps[t] > 0)
                                peak_reps[t]--;
                            if (peak_reps[t] == 0)
                                peak_count--;
                        end
                    end
                end
            end
            default:
            begin
                // Peek, and the spare action code behaves the same way.
                if (elem_count == 0)
                    r.status = STATUS_EMPTY;
            end
        endcase

        if (elem_count == 0)
            r.is_empty = 1'b1;
        else
        begin
            r.top_value = stack_elems[elem_count - 1];
            r.max_value = (peak_count != 0) ? peak_vals[peak_count - 1] : '0;
            r.is_empty  = 1'b0;
        end
        return r;
    endfunction

    // Compare one field and report it when it differs.
    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            fail_count++;
            $display("%0t: %s expected %h actual %h", $time, name, exp_val, act_val);
        end
    endtask

    // Responses are retired before the command of the same edge is predicted,
    // since a response always belongs to an earlier command.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_count = 0;
            peak_count = 0;
            expected_rsps.delete();
            pending_results <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: response item with nothing expected, actual %h",
                             $time, rsp);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    check_field("status", want.status, rsp.status);
                    check_field("popped_value", want.popped_value, rsp.popped_value);
                    check_field("top_value", want.top_value, rsp.top_value);
                    check_field("max_value", want.max_value, rsp.max_value);
                    check_field("is_empty", want.is_empty, rsp.is_empty);
                end
            end
            if (cmd_valid && cmd_ready)
                expected_rsps.push_back(apply_stack_op(cmd));
            pending_results <= expected_rsps.size();
        end
    end

endmodule

### tb/max_tracking_stack_unit_tb.sv
`timescale 1ns / 1ps

// Drives push, pop and peek items into the max-tracking stack under several
// idling patterns and gives the verdict from the checker's failure count.
module max_tracking_stack_unit_tb;

    import mts_pkg::*;

    // The action code that the block treats as a peek.
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam value_t MAX_POS = 32'sh7FFF_FFFF;
    localparam value_t MIN_NEG = 32'sh8000_0000;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 150;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  cmd_valid = 1'b0;
    logic  cmd_ready;
    cmd_t  cmd       = '0;
    logic  rsp_valid;
    logic  rsp_ready = 1'b0;
    rsp_t  rsp;

    int    fail_count;
    int    pending_results;

    int    send_idle_pct   = 0;
    int    recv_stall_pct  = 0;
    int    hold_cycles_req = 0;

    max_tracking_stack_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    max_tracking_stack_checker chk
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .cmd             (cmd),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .rsp             (rsp),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("max_tracking_stack_unit: mismatch");
        $finish;
    end

    // Response side: random stalls, or a long hold-off when one is requested.
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (hold_cycles_req > 0)
            begin
                n = hold_cycles_req;
                hold_cycles_req = 0;
                rsp_ready <= 1'b0;
                repeat (n - 1)
                begin
                    @(negedge clk);
                    rsp_ready <= 1'b0;
                end
            end
            else
                rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic apply_idle_mode(input idle_mode_t mode);
        send_idle_pct  = (mode == IDLE_SEND) ? 45 : (mode == IDLE_BOTH) ? 15 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 45 : (mode == IDLE_BOTH) ? 15 : 0;
    endtask

    // Offer one item, with random gaps ahead of it, and return once accepted.
    task automatic send_stack_cmd(input cmd_t c);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
    endtask

    task automatic send_op(input logic [1:0] act, input value_t val);
        cmd_t c;
        c.action     = act;
        c.data_value = val;
        send_stack_cmd(c);
    endtask

    // Stop offering items until every predicted response has come back.
    task automatic wait_results_drained();
        @(negedge clk);
        cmd_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results != 0);
    endtask

    // Random item: pushes draw often from a small pool so that equal maxima
    // repeat, sometimes from the extremes, otherwise from the full range.
    function automatic cmd_t random_stack_cmd(input int push_pct);
        cmd_t c;
        int   kind;
        c.data_value = $urandom;
        if ($urandom_range(99) < push_pct)
            c.action = ACT_PUSH;
        else
        begin
            kind = $urandom_range(19);
            if (kind < 15)
                c.action = ACT_POP;
            else if (kind < 18)
                c.action = ACT_PEEK;
            else
                c.action = ACT_SPARE;
        end
        if (c.action == ACT_PUSH)
        begin
            kind = $urandom_range(9);
            if (kind < 5)
                c.data_value = int'($urandom_range(8)) - 4;
            else if (kind < 7)
            begin
                case ($urandom_range(3))
                    0: c.data_value = MAX_POS;
                    1: c.data_value = MIN_NEG;
                    2: c.data_value = '0;
                    default: c.data_value = -1;
                endcase
            end
        end
        return c;
    endfunction

    initial
    begin
        int push_pct [4];
        int ph;
        int i;
        push_pct = '{55, 45, 60, 40};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty-stack errors, extremes, repeated and smaller values.
        apply_idle_mode(IDLE_NONE);
        send_op(ACT_PEEK, 0);
        send_op(ACT_POP, 0);
        send_op(ACT_SPARE, 0);
        send_op(ACT_PUSH, 5);
        send_op(ACT_PUSH, 5);
        send_op(ACT_PUSH, 3);
        send_op(ACT_PUSH, MAX_POS);
        send_op(ACT_PUSH, MAX_POS);
        send_op(ACT_PUSH, MIN_NEG);
        send_op(ACT_PUSH, 0);
        send_op(ACT_PEEK, 0);
        send_op(ACT_SPARE, -1);
        send_op(ACT_POP, 0);
        send_op(ACT_POP, 0);
        send_op(ACT_POP, 0);
        send_op(ACT_POP, 0);
        send_op(ACT_POP, 0);
        send_op(ACT_POP, 0);
        send_op(ACT_POP, 0);
        send_op(ACT_POP, 0);
        send_op(ACT_PUSH, -1);
        send_op(ACT_PUSH, -2);
        send_op(ACT_PUSH, -1);
        send_op(ACT_PEEK, 0);

        // Random phases, cycling through the idling patterns.
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            apply_idle_mode(idle_mode_t'(ph % 4));
            if (ph == 4)
                wait_results_drained();
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // Long receiver hold-off while items keep coming.
                if (ph == 0 && i == 60)
                    hold_cycles_req = 200;
                send_stack_cmd(random_stack_cmd(push_pct[ph % 4]));
            end
        end

        // Fill past capacity so that pushes are refused, then drain past empty.
        apply_idle_mode(IDLE_BOTH);
        for (i = 0; i < 320; i++)
        begin
            if (i == 290)
                hold_cycles_req = 100;
            send_stack_cmd(random_stack_cmd(95));
        end
        apply_idle_mode(IDLE_RECV);
        for (i = 0; i < 400; i++)
            send_stack_cmd(random_stack_cmd(5));

        wait_results_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("max_tracking_stack_unit: match");
        else
            $display("max_tracking_stack_unit: mismatch");
        $finish;
    end

endmodule

### max_tracking_stack_unit.f
hdl/mts_pkg.sv
hdl/mts_cell.sv
hdl/mts_ctrl.sv
hdl/max_tracking_stack_unit.sv
tb/max_tracking_stack_checker.sv
tb/max_tracking_stack_unit_tb.sv
